@@ hdl/utc_pkg.sv @@
`default_nettype none

package utc_pkg;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_ODD_LENGTH    = 2'd1,
      STATUS_UNPAIRED_HIGH = 2'd2,
      STATUS_BAD_PAIR      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      JOB_RAW  = 2'd0,
      JOB_CODE = 2'd1,
      JOB_MARK = 2'd2
   } job_kind_type;

   // A raw job carries up to three bytes, lowest byte first. A code job carries a
   // code point in the low 21 bits. A mark job carries no byte, only its status.
   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   raw_count;
      logic [23:0]  data;
      status_type   status;
      logic         last;
   } job_type;

   localparam logic [7:0]  UTF8_MARK_0        = 8'hEF;
   localparam logic [7:0]  UTF8_MARK_1        = 8'hBB;
   localparam logic [7:0]  UTF8_MARK_2        = 8'hBF;
   localparam logic [7:0]  UTF16_MARK_FF      = 8'hFF;
   localparam logic [7:0]  UTF16_MARK_FE      = 8'hFE;
   localparam logic [5:0]  HIGH_SURR_TAG      = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG       = 6'b110111;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

endpackage

`default_nettype wire

@@ hdl/utc_if.sv @@
`default_nettype none

interface utc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface utc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output has_byte, output out_last,
                   output status, input ready);
   modport sink (input valid, input out_byte, input has_byte, input out_last,
                 input status, output ready);
endinterface

`default_nettype wire

@@ hdl/utc_front.sv @@
`default_nettype none

module utc_front (
   input  wire logic          clock,
   input  wire logic          reset,
   utc_req_if.sink            req_bus,
   input  wire logic          queue_full,
   output logic               push_valid,
   output utc_pkg::job_type   push_job
);
   import utc_pkg::*;

   typedef enum logic [3:0] {
      MODE_DETECT = 4'b0001,
      MODE_PASS   = 4'b0010,
      MODE_LE     = 4'b0100,
      MODE_BE     = 4'b1000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  head_count_ff, head_count_in;
   logic [7:0]  head_byte_ff, head_byte_in;
   logic [7:0]  half_unit_ff, half_unit_in;
   logic        half_pending_ff, half_pending_in;
   logic [9:0]  high_surr_ff, high_surr_in;
   logic        high_pending_ff, high_pending_in;
   logic        dropping_ff, dropping_in;

   logic        accept;
   logic [7:0]  in_byte;
   logic        in_last;
   logic [15:0] unit;
   logic        job_made;
   job_type     job;

   assign in_byte       = req_bus.in_byte;
   assign in_last       = req_bus.in_last;
   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign unit          = (mode_ff == MODE_LE) ? {in_byte, half_unit_ff}
                                               : {half_unit_ff, in_byte};

   always_comb begin
      mode_in         = mode_ff;
      head_count_in   = head_count_ff;
      head_byte_in    = head_byte_ff;
      half_unit_in    = half_unit_ff;
      half_pending_in = half_pending_ff;
      high_surr_in    = high_surr_ff;
      high_pending_in = high_pending_ff;
      dropping_in     = dropping_ff;
      job_made        = 1'b0;
      job.kind        = JOB_RAW;
      job.raw_count   = 2'd1;
      job.data        = {16'd0, in_byte};
      job.status      = STATUS_OK;
      job.last        = in_last;

      if (accept && !dropping_ff) begin
         case (mode_ff)
            MODE_DETECT: begin
               case (head_count_ff)
                  2'd0: begin
                     if (!in_last && (in_byte == UTF8_MARK_0 || in_byte == UTF16_MARK_FF ||
                                      in_byte == UTF16_MARK_FE)) begin
                        head_byte_in  = in_byte;
                        head_count_in = 2'd1;
                     end else begin
                        job_made = 1'b1;
                        mode_in  = MODE_PASS;
                     end
                  end
                  2'd1: begin
                     head_count_in = 2'd0;
                     if (head_byte_ff == UTF8_MARK_0 && in_byte == UTF8_MARK_1 && !in_last) begin
                        head_count_in = 2'd2;
                     end else if (head_byte_ff == UTF16_MARK_FF && in_byte == UTF16_MARK_FE) begin
                        mode_in = MODE_LE;
                     end else if (head_byte_ff == UTF16_MARK_FE && in_byte == UTF16_MARK_FF) begin
                        mode_in = MODE_BE;
                     end else begin
                        job_made      = 1'b1;
                        job.raw_count = 2'd2;
                        job.data      = {8'd0, in_byte, head_byte_ff};
                        mode_in       = MODE_PASS;
                     end
                  end
                  default: begin
                     head_count_in = 2'd0;
                     mode_in       = MODE_PASS;
                     if (in_byte != UTF8_MARK_2) begin
                        job_made      = 1'b1;
                        job.raw_count = 2'd3;
                        job.data      = {in_byte, UTF8_MARK_1, UTF8_MARK_0};
                     end
                  end
               endcase
            end
            MODE_PASS: begin
               job_made = 1'b1;
            end
            MODE_LE, MODE_BE: begin
               if (!half_pending_ff) begin
                  half_unit_in    = in_byte;
                  half_pending_in = 1'b1;
                  if (in_last) begin
                     job_made   = 1'b1;
                     job.kind   = JOB_MARK;
                     job.status = STATUS_ODD_LENGTH;
                  end
               end else begin
                  half_pending_in = 1'b0;
                  if (high_pending_ff) begin
                     high_pending_in = 1'b0;
                     job_made        = 1'b1;
                     if (unit[15:10] != LOW_SURR_TAG) begin
                        job.kind    = JOB_MARK;
                        job.status  = STATUS_BAD_PAIR;
                        dropping_in = 1'b1;
                     end else begin
                        job.kind = JOB_CODE;
                        job.data = {3'd0, SUPPLEMENTARY_BASE +
                                          {1'b0, high_surr_ff, unit[9:0]}};
                     end
                  end else if (unit[15:10] == HIGH_SURR_TAG) begin
                     high_surr_in    = unit[9:0];
                     high_pending_in = 1'b1;
                     if (in_last) begin
                        job_made   = 1'b1;
                        job.kind   = JOB_MARK;
                        job.status = STATUS_UNPAIRED_HIGH;
                     end
                  end else begin
                     job_made = 1'b1;
                     job.kind = JOB_CODE;
                     job.data = {8'd0, unit};
                  end
               end
            end
            default: begin
               mode_in = MODE_DETECT;
            end
         endcase
      end

      if (accept && in_last) begin
         if (!dropping_ff && !job_made) begin
            job_made   = 1'b1;
            job.kind   = JOB_MARK;
            job.status = STATUS_OK;
         end
         mode_in         = MODE_DETECT;
         head_count_in   = 2'd0;
         half_pending_in = 1'b0;
         high_pending_in = 1'b0;
         dropping_in     = 1'b0;
      end
   end

   assign push_valid = job_made;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_DETECT;
         head_count_ff   <= 2'd0;
         half_pending_ff <= 1'b0;
         high_pending_ff <= 1'b0;
         dropping_ff     <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         head_count_ff   <= head_count_in;
         half_pending_ff <= half_pending_in;
         high_pending_ff <= high_pending_in;
         dropping_ff     <= dropping_in;
      end
   end

   always_ff @(posedge clock) begin
      head_byte_ff <= head_byte_in;
      half_unit_ff <= half_unit_in;
      high_surr_ff <= high_surr_in;
   end

endmodule

`default_nettype wire

@@ hdl/utc_queue.sv @@
`default_nettype none

module utc_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire utc_pkg::job_type push_job,
   output logic                  full,
   output logic                  pop_valid,
   output utc_pkg::job_type      pop_job,
   input  wire logic             pop_ready
);
   import utc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("job offered while the queue is full");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not grow on a push");
`endif

endmodule

`default_nettype wire

@@ hdl/utc_back.sv @@
`default_nettype none

module utc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   input  wire utc_pkg::job_type pop_job,
   output logic                  pop_ready,
   utc_rsp_if.source             rsp_bus
);
   import utc_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_has_ff, rsp_has_in;
   logic        rsp_last_ff, rsp_last_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rest_ff [3];
   logic [7:0]  rest_in [3];
   logic [1:0]  left_ff, left_in;
   logic        job_last_ff, job_last_in;

   logic        advance;
   logic [20:0] cp;
   logic [7:0]  enc [4];
   logic [2:0]  enc_count;
   logic        enc_has;
   status_type  enc_status;

   assign advance   = !rsp_valid_ff || rsp_bus.ready;
   assign pop_ready = advance && (left_ff == 2'd0);
   assign cp        = pop_job.data[20:0];

   always_comb begin
      enc[0]     = 8'd0;
      enc[1]     = 8'd0;
      enc[2]     = 8'd0;
      enc[3]     = 8'd0;
      enc_count  = 3'd1;
      enc_has    = 1'b1;
      enc_status = STATUS_OK;
      case (pop_job.kind)
         JOB_RAW: begin
            enc[0]    = pop_job.data[7:0];
            enc[1]    = pop_job.data[15:8];
            enc[2]    = pop_job.data[23:16];
            enc_count = {1'b0, pop_job.raw_count};
         end
         JOB_CODE: begin
            if (cp[20:7] == '0) begin
               enc[0] = cp[7:0];
            end else if (cp[20:11] == '0) begin
               enc[0]    = {3'b110, cp[10:6]};
               enc[1]    = {2'b10, cp[5:0]};
               enc_count = 3'd2;
            end else if (cp[20:16] == '0) begin
               enc[0]    = {4'b1110, cp[15:12]};
               enc[1]    = {2'b10, cp[11:6]};
               enc[2]    = {2'b10, cp[5:0]};
               enc_count = 3'd3;
            end else begin
               enc[0]    = {5'b11110, cp[20:18]};
               enc[1]    = {2'b10, cp[17:12]};
               enc[2]    = {2'b10, cp[11:6]};
               enc[3]    = {2'b10, cp[5:0]};
               enc_count = 3'd4;
            end
         end
         default: begin
            enc_has    = 1'b0;
            enc_status = pop_job.status;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rest_in[0]    = rest_ff[0];
      rest_in[1]    = rest_ff[1];
      rest_in[2]    = rest_ff[2];
      left_in       = left_ff;
      job_last_in   = job_last_ff;
      if (advance) begin
         if (left_ff != 2'd0) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = rest_ff[0];
            rsp_has_in    = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = job_last_ff && (left_ff == 2'd1);
            rest_in[0]    = rest_ff[1];
            rest_in[1]    = rest_ff[2];
            left_in       = left_ff - 2'd1;
         end else if (pop_valid) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = enc[0];
            rsp_has_in    = enc_has;
            rsp_status_in = enc_status;
            rsp_last_in   = pop_job.last && (enc_count == 3'd1);
            rest_in[0]    = enc[1];
            rest_in[1]    = enc[2];
            rest_in[2]    = enc[3];
            left_in       = 2'(enc_count - 3'd1);
            job_last_in   = pop_job.last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rest_ff       <= rest_in;
      job_last_ff   <= job_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.has_byte = rsp_has_ff;
   assign rsp_bus.out_last = rsp_last_ff;
   assign rsp_bus.status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_pending_needs_output: assert property (@(posedge clock) disable iff (reset)
      (left_ff != 2'd0) |-> rsp_valid_ff)
      else $error("bytes pending behind an empty output register");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (left_ff == 2'd0))
      else $error("final beat shown with bytes still pending");

   a_marker_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> (rsp_last_ff || rsp_status_ff == STATUS_BAD_PAIR))
      else $error("marker beat that neither ends a file nor reports a bad pair");

   a_data_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_has_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("data beat with an error status");
`endif

endmodule

`default_nettype wire

@@ hdl/utf16_to_utf8_transcoder.sv @@
`default_nettype none

// Converts a byte stream, one file at a time with the last byte marked, to UTF-8.
// A leading UTF-8 mark is stripped, a UTF-16 mark selects little- or big-endian
// decoding, and anything else passes through. Errors come in-stream as a beat with
// has_byte low and a nonzero status, after which the rest of the file is dropped;
// bytes already sent for that file must be discarded downstream. The front stage
// takes one input beat per cycle and turns it into at most one job, which waits in
// a QUEUE_DEPTH-entry queue; the back stage sends one result beat per cycle while
// the output is not stalled, and a job of several bytes holds the back stage until
// its last byte is sent. The input side stalls only when the queue is full. The job
// of an accepted byte goes into the queue, then the back stage registers its first
// result in the output register. Reset returns the block to the start of a file.
module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   utc_req_if.sink    req_bus,
   utc_rsp_if.source  rsp_bus
);
   import utc_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop_valid;
   job_type pop_job;
   logic    pop_ready;

   utc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   utc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   utc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

@@ dv/utf8_stream_checker.sv @@
module utf8_stream_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   utc_req_if          req_bus,
   utc_rsp_if          rsp_bus,
   output int unsigned mismatch_count,
   output int unsigned pending_beats
);
   import utc_pkg::*;

   typedef enum logic [1:0] {
      DEC_DETECT,
      DEC_PASS,
      DEC_LE,
      DEC_BE
   } decode_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
      status_type status;
   } utf8_beat_type;

   decode_mode_type mode;
   logic [1:0]      head_count;
   logic [7:0]      head_byte;
   logic [7:0]      half_unit;
   logic            half_pending;
   logic [9:0]      high_bits;
   logic            high_pending;
   logic            dropping;

   utf8_beat_type   utf8_expected_q[$];
   utf8_beat_type   step_beats[$];

   function automatic void clear_decoder();
      mode         = DEC_DETECT;
      head_count   = 2'd0;
      head_byte    = 8'h00;
      half_unit    = 8'h00;
      half_pending = 1'b0;
      high_bits    = 10'd0;
      high_pending = 1'b0;
      dropping     = 1'b0;
   endfunction

   function automatic void emit(input logic [7:0] b, input logic has, input status_type st);
      utf8_beat_type beat;
      beat.out_byte = has ? b : 8'h00;
      beat.has_byte = has;
      beat.out_last = 1'b0;
      beat.status   = st;
      if (step_beats.size() < 4) begin
         step_beats = {step_beats, beat};
      end
   endfunction

   function automatic void emit_code_point(input logic [20:0] c);
      if (c < 21'h80) begin
         emit(c[7:0], 1'b1, STATUS_OK);
      end else if (c < 21'h800) begin
         emit({3'b110, c[10:6]}, 1'b1, STATUS_OK);
         emit({2'b10, c[5:0]}, 1'b1, STATUS_OK);
      end else if (c < 21'h10000) begin
         emit({4'b1110, c[15:12]}, 1'b1, STATUS_OK);
         emit({2'b10, c[11:6]}, 1'b1, STATUS_OK);
         emit({2'b10, c[5:0]}, 1'b1, STATUS_OK);
      end else begin
         emit({5'b11110, c[20:18]}, 1'b1, STATUS_OK);
         emit({2'b10, c[17:12]}, 1'b1, STATUS_OK);
         emit({2'b10, c[11:6]}, 1'b1, STATUS_OK);
         emit({2'b10, c[5:0]}, 1'b1, STATUS_OK);
      end
   endfunction

   function automatic void detect_head(input logic [7:0] b, input logic last);
      if (head_count == 2'd0) begin
         if (!last && (b == UTF8_MARK_0 || b == UTF16_MARK_FF || b == UTF16_MARK_FE)) begin
            head_byte  = b;
            head_count = 2'd1;
         end else begin
            emit(b, 1'b1, STATUS_OK);
            mode = DEC_PASS;
         end
      end else if (head_count == 2'd1) begin
         head_count = 2'd0;
         if (head_byte == UTF8_MARK_0 && b == UTF8_MARK_1 && !last) begin
            head_count = 2'd2;
         end else if (head_byte == UTF16_MARK_FF && b == UTF16_MARK_FE) begin
            mode = DEC_LE;
         end else if (head_byte == UTF16_MARK_FE && b == UTF16_MARK_FF) begin
            mode = DEC_BE;
         end else begin
            emit(head_byte, 1'b1, STATUS_OK);
            emit(b, 1'b1, STATUS_OK);
            mode = DEC_PASS;
         end
      end else begin
         if (b != UTF8_MARK_2) begin
            emit(UTF8_MARK_0, 1'b1, STATUS_OK);
            emit(UTF8_MARK_1, 1'b1, STATUS_OK);
            emit(b, 1'b1, STATUS_OK);
         end
         mode       = DEC_PASS;
         head_count = 2'd0;
      end
   endfunction

   function automatic void decode_utf16(input logic [7:0] b, input logic last);
      logic [15:0] unit;
      if (!half_pending) begin
         half_unit    = b;
         half_pending = 1'b1;
         if (last) begin
            emit(8'h00, 1'b0, STATUS_ODD_LENGTH);
         end
      end else begin
         half_pending = 1'b0;
         unit = (mode == DEC_LE) ? {b, half_unit} : {half_unit, b};
         if (high_pending) begin
            high_pending = 1'b0;
            if (unit[15:10] != LOW_SURR_TAG) begin
               emit(8'h00, 1'b0, STATUS_BAD_PAIR);
               dropping = 1'b1;
            end else begin
               emit_code_point(SUPPLEMENTARY_BASE + {1'b0, high_bits, unit[9:0]});
            end
         end else if (unit[15:10] == HIGH_SURR_TAG) begin
            high_bits    = unit[9:0];
            high_pending = 1'b1;
            if (last) begin
               emit(8'h00, 1'b0, STATUS_UNPAIRED_HIGH);
            end
         end else begin
            emit_code_point({5'd0, unit});
         end
      end
   endfunction

   function automatic void transcode_byte(input logic [7:0] b, input logic last);
      step_beats.delete();
      if (dropping) begin
         if (last) begin
            clear_decoder();
         end
      end else begin
         case (mode)
            DEC_DETECT: begin
               detect_head(b, last);
            end
            DEC_LE, DEC_BE: begin
               decode_utf16(b, last);
            end
            default: begin
               emit(b, 1'b1, STATUS_OK);
            end
         endcase
         if (last) begin
            if (step_beats.size() == 0) begin
               emit(8'h00, 1'b0, STATUS_OK);
            end
            step_beats[step_beats.size() - 1].out_last = 1'b1;
            clear_decoder();
         end
         foreach (step_beats[i]) begin
            utf8_expected_q = {utf8_expected_q, step_beats[i]};
         end
      end
   endfunction

   always @(posedge clock) begin
      utf8_beat_type got;
      utf8_beat_type want;
      if (reset) begin
         clear_decoder();
         utf8_expected_q.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            transcode_byte(req_bus.in_byte, req_bus.in_last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.out_byte = rsp_bus.out_byte;
            got.has_byte = rsp_bus.has_byte;
            got.out_last = rsp_bus.out_last;
            got.status   = status_type'(rsp_bus.status);
            if (utf8_expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("[%0t] unexpected result beat: byte %02h has %0b last %0b status %0d",
                           $realtime, got.out_byte, got.has_byte, got.out_last, got.status);
               end
            end else begin
               want = utf8_expected_q.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] expected byte %02h has %0b last %0b status %0d",
                              $realtime, want.out_byte, want.has_byte, want.out_last,
                              want.status);
                     $display("[%0t]      got byte %02h has %0b last %0b status %0d",
                              $realtime, got.out_byte, got.has_byte, got.out_last, got.status);
                  end
               end
            end
         end
      end
      pending_beats = utf8_expected_q.size();
   end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   import utc_pkg::*;

   logic        clock;
   logic        reset;
   bit          quiet_stretch;
   bit          pressure_go;
   int unsigned mismatch_count;
   int unsigned pending_beats;
   int unsigned bytes_sent;
   logic [7:0]  file_bytes[$];

   utc_req_if req_bus ();
   utc_rsp_if rsp_bus ();

   utf16_to_utf8_transcoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   utf8_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      while (!quiet_stretch && $urandom_range(0, 99) < 15) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) begin
         send_beat(file_bytes[i], i == file_bytes.size() - 1);
      end
      file_bytes.delete();
   endtask

   function automatic void add_byte(input logic [7:0] b);
      file_bytes = {file_bytes, b};
   endfunction

   function automatic void push_unit(input logic [15:0] u, input bit le);
      if (le) begin
         add_byte(u[7:0]);
         add_byte(u[15:8]);
      end else begin
         add_byte(u[15:8]);
         add_byte(u[7:0]);
      end
   endfunction

   function automatic logic [15:0] random_high();
      return {HIGH_SURR_TAG, 10'($urandom_range(0, 1023))};
   endfunction

   function automatic logic [15:0] random_low();
      return {LOW_SURR_TAG, 10'($urandom_range(0, 1023))};
   endfunction

   function automatic logic [15:0] random_non_low();
      if ($urandom_range(0, 1)) begin
         return 16'($urandom_range(0, 16'hDBFF));
      end
      return 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   function automatic void push_random_char(input bit le);
      case ($urandom_range(0, 5))
         0: push_unit(16'($urandom_range(0, 16'h7F)), le);
         1: push_unit(16'($urandom_range(16'h80, 16'h7FF)), le);
         2: push_unit(16'($urandom_range(16'h800, 16'hD7FF)), le);
         3: push_unit(16'($urandom_range(16'hE000, 16'hFFFF)), le);
         4: begin
            push_unit(random_high(), le);
            push_unit(random_low(), le);
         end
         default: push_unit(random_low(), le);
      endcase
   endfunction

   function automatic void build_utf16_file();
      bit le;
      int units;
      le = 1'($urandom_range(0, 1));
      if (le) begin
         add_byte(UTF16_MARK_FF);
         add_byte(UTF16_MARK_FE);
      end else begin
         add_byte(UTF16_MARK_FE);
         add_byte(UTF16_MARK_FF);
      end
      units = $urandom_range(0, 4);
      repeat (units) push_random_char(le);
      case ($urandom_range(0, 9))
         0: add_byte(8'($urandom_range(0, 255)));
         1: push_unit(random_high(), le);
         2: begin
            push_unit(random_high(), le);
            push_unit(random_non_low(), le);
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endfunction

   function automatic void build_random_file();
      case ($urandom_range(0, 9))
         0, 1: begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         end
         2: begin
            add_byte(UTF8_MARK_0);
            add_byte(UTF8_MARK_1);
            add_byte(UTF8_MARK_2);
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
         end
         3: begin
            case ($urandom_range(0, 5))
               0: add_byte(UTF8_MARK_0);
               1: begin
                  add_byte(UTF8_MARK_0);
                  add_byte(UTF8_MARK_1);
               end
               2: add_byte($urandom_range(0, 1) ? UTF16_MARK_FF : UTF16_MARK_FE);
               3: begin
                  add_byte(UTF16_MARK_FF);
                  add_byte(UTF16_MARK_FE);
               end
               4: begin
                  add_byte(UTF8_MARK_0);
                  add_byte(UTF8_MARK_1);
                  add_byte(8'($urandom_range(0, 255)));
                  repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
               end
               default: begin
                  case ($urandom_range(0, 2))
                     0: add_byte(UTF8_MARK_0);
                     1: add_byte(UTF16_MARK_FF);
                     default: add_byte(UTF16_MARK_FE);
                  endcase
                  repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
               end
            endcase
         end
         default: build_utf16_file();
      endcase
   endfunction

   initial begin : receiver
      int unsigned hold_left;
      bit          pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !pressure_done) begin
            hold_left     = 300;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= quiet_stretch || $urandom_range(0, 99) >= 15;
         end
      end
   end

   initial begin : stimulus
      int unsigned random_start;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      reset           = 1'b1;
      bytes_sent      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      file_bytes = '{UTF16_MARK_FE, UTF16_MARK_FF};
      send_file();
      file_bytes = '{UTF16_MARK_FE, UTF16_MARK_FF, 8'hDB, 8'hFF, 8'hDF, 8'hFF,
                     8'h07, 8'hFF, 8'h00};
      send_file();
      file_bytes = '{UTF16_MARK_FF, UTF16_MARK_FE, 8'h00, 8'hDC, 8'hAC, 8'h20,
                     8'h00, 8'hD8};
      send_file();
      file_bytes = '{UTF16_MARK_FE, UTF16_MARK_FF, 8'hD8, 8'h00, 8'h00, 8'h41, 8'hFF};
      send_file();

      pressure_go  = 1'b1;
      random_start = bytes_sent;
      while (bytes_sent < random_start + 70) begin
         quiet_stretch = (bytes_sent >= random_start + 25) && (bytes_sent < random_start + 55);
         build_random_file();
         send_file();
      end
      quiet_stretch = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending_beats != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("utf16_to_utf8_transcoder: match");
      end else begin
         $display("utf16_to_utf8_transcoder: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("utf16_to_utf8_transcoder: mismatch");
      $finish;
   end

endmodule
